@@ rtl/assert_macros.svh @@
// Concurrent check helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, quiet while reset is asserted.
`define SST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define SST_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/sst_pkg.sv @@
`timescale 1ns / 1ps

package sst_pkg;

	localparam int MAX_DEPTH_DEF   = 64;
	localparam int OFFSET_BITS_DEF = 32;

	typedef enum logic [3:0] {
		EV_OPEN     = 4'd0,
		EV_CLOSE    = 4'd1,
		EV_ABYTE    = 4'd2,
		EV_AEND     = 4'd3,
		EV_SBYTE    = 4'd4,
		EV_SEND     = 4'd5,
		EV_DONE     = 4'd6,
		EV_UNEXP    = 4'd7,
		EV_MISSING  = 4'd8,
		EV_UNTERM   = 4'd9,
		EV_OVERFLOW = 4'd10
	} event_t;

	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_VT        = 8'h0B;
	localparam logic [7:0] CH_FF        = 8'h0C;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef struct packed {
		logic       kind;
		logic [7:0] text_byte;
	} char_item_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  value;
		logic [6:0]  nest_depth;
		logic [31:0] byte_offset;
		logic        last;
	} res_item_t;

	// Up to two result words per input word.
	typedef struct packed {
		logic [1:0] count;
		res_item_t  first;
		res_item_t  second;
	} res_pair_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {CH_SPACE, CH_LF, CH_CR, CH_TAB, CH_VT, CH_FF};
	endfunction

endpackage

@@ rtl/sst_stream_if.sv @@
`timescale 1ns / 1ps

interface sst_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sst_ram.sv @@
`timescale 1ns / 1ps

module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sst_lexer.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sst_lexer #(
	parameter int MAX_DEPTH   = sst_pkg::MAX_DEPTH_DEF,
	parameter int OFFSET_BITS = sst_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	sst_stream_if.sink         char_stream,
	input  logic               take,
	output logic               load,
	output sst_pkg::res_pair_t pair
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int DX = (DW > 7) ? DW : 7;
	localparam int OX = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	typedef enum logic [2:0] {
		M_BETWEEN,
		M_COMMENT,
		M_ATOM,
		M_STRING,
		M_ESCAPE,
		M_ERROR
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [DW-1:0]          depth_q, depth_d, depth_nx;
	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] sstart_q, sstart_d;
	logic                   s1_valid_q;
	logic                   kind_s1;
	logic [7:0]             byte_s1;
	logic                   byp_q;
	logic [OFFSET_BITS-1:0] byp_data_q;

	logic                   advance;
	logic                   push;
	logic                   we;
	logic [AW-1:0]          waddr, raddr;
	logic [OFFSET_BITS-1:0] rdata, top;

	logic                   aend, bev_v, run_between;
	sst_pkg::res_item_t     bev, tail;
	sst_pkg::res_pair_t     pair_d;
	logic [7:0]             c, esc;

	function automatic sst_pkg::res_item_t mk(
		input sst_pkg::event_t        ev,
		input logic [7:0]             val,
		input logic [DW-1:0]          d,
		input logic [OFFSET_BITS-1:0] o
	);
		sst_pkg::res_item_t r;
		logic [DX-1:0]      dw;
		logic [OX-1:0]      ow;
		dw = DX'(d);
		ow = OX'(o);
		r.event_res   = ev;
		r.value       = val;
		r.nest_depth  = dw[6:0];
		r.byte_offset = ow[31:0];
		r.last        = 1'b0;
		return r;
	endfunction

	assign advance           = s1_valid_q && take;
	assign char_stream.ready = !s1_valid_q || take;
	assign c                 = byte_s1;

	always_comb begin
		case (c)
			sst_pkg::CH_N: esc = sst_pkg::CH_LF;
			sst_pkg::CH_R: esc = sst_pkg::CH_CR;
			sst_pkg::CH_T: esc = sst_pkg::CH_TAB;
			default:       esc = c;
		endcase
	end

	always_comb begin
		mode_d      = mode_q;
		depth_d     = depth_q;
		pos_d       = pos_q;
		sstart_d    = sstart_q;
		push        = 1'b0;
		aend        = 1'b0;
		bev_v       = 1'b0;
		bev         = '0;
		tail        = '0;
		run_between = 1'b0;
		pair_d      = '0;

		if (kind_s1) begin
			// end of text: report, then return mode, depth, position and string start to their reset values
			mode_d   = M_BETWEEN;
			depth_d  = '0;
			pos_d    = '0;
			sstart_d = '0;
			case (mode_q)
				M_ERROR: begin
				end
				M_STRING, M_ESCAPE: begin
					pair_d.count = 2'd1;
					pair_d.first = mk(sst_pkg::EV_UNTERM, 8'h00, depth_q, sstart_q);
				end
				default: begin
					if (depth_q != '0) begin
						tail = mk(sst_pkg::EV_MISSING, 8'h00, depth_q, top);
					end else begin
						tail = mk(sst_pkg::EV_DONE, 8'h00, depth_q, pos_q);
					end
					if (mode_q == M_ATOM) begin
						pair_d.count  = 2'd2;
						pair_d.first  = mk(sst_pkg::EV_AEND, 8'h00, depth_q, pos_q);
						pair_d.second = tail;
					end else begin
						pair_d.count = 2'd1;
						pair_d.first = tail;
					end
				end
			endcase
		end else begin
			pos_d = pos_q + 1'b1;
			case (mode_q)
				M_BETWEEN: run_between = 1'b1;
				M_COMMENT: begin
					if (c == sst_pkg::CH_LF) begin
						mode_d = M_BETWEEN;
					end
				end
				M_ATOM: begin
					if (sst_pkg::is_ws(c) || c == sst_pkg::CH_LPAREN ||
					    c == sst_pkg::CH_RPAREN) begin
						aend        = 1'b1;
						mode_d      = M_BETWEEN;
						run_between = 1'b1;
					end else begin
						bev_v = 1'b1;
						bev   = mk(sst_pkg::EV_ABYTE, c, depth_q, pos_q);
					end
				end
				M_STRING: begin
					if (c == sst_pkg::CH_QUOTE) begin
						bev_v  = 1'b1;
						bev    = mk(sst_pkg::EV_SEND, 8'h00, depth_q, pos_q);
						mode_d = M_BETWEEN;
					end else if (c == sst_pkg::CH_BSLASH) begin
						mode_d = M_ESCAPE;
					end else begin
						bev_v = 1'b1;
						bev   = mk(sst_pkg::EV_SBYTE, c, depth_q, pos_q);
					end
				end
				M_ESCAPE: begin
					bev_v  = 1'b1;
					bev    = mk(sst_pkg::EV_SBYTE, esc, depth_q, pos_q);
					mode_d = M_STRING;
				end
				default: mode_d = M_ERROR;
			endcase

			if (run_between && !sst_pkg::is_ws(c)) begin
				if (c == sst_pkg::CH_SEMI || c == sst_pkg::CH_HASH) begin
					mode_d = M_COMMENT;
				end else if (c == sst_pkg::CH_LPAREN) begin
					bev_v = 1'b1;
					if (depth_q >= DW'(MAX_DEPTH)) begin
						// saturate: depth is already at the limit
						bev    = mk(sst_pkg::EV_OVERFLOW, 8'h00, DW'(MAX_DEPTH), pos_q);
						mode_d = M_ERROR;
					end else begin
						push    = 1'b1;
						depth_d = depth_q + 1'b1;
						bev     = mk(sst_pkg::EV_OPEN, 8'h00, depth_d, pos_q);
					end
				end else if (c == sst_pkg::CH_RPAREN) begin
					bev_v = 1'b1;
					if (depth_q == '0) begin
						bev    = mk(sst_pkg::EV_UNEXP, 8'h00, depth_q, pos_q);
						mode_d = M_ERROR;
					end else begin
						depth_d = depth_q - 1'b1;
						bev     = mk(sst_pkg::EV_CLOSE, 8'h00, depth_d, pos_q);
					end
				end else if (c == sst_pkg::CH_QUOTE) begin
					sstart_d = pos_q;
					mode_d   = M_STRING;
				end else begin
					bev_v  = 1'b1;
					bev    = mk(sst_pkg::EV_ABYTE, c, depth_q, pos_q);
					mode_d = M_ATOM;
				end
			end

			if (aend) begin
				pair_d.first = mk(sst_pkg::EV_AEND, 8'h00, depth_q, pos_q);
				if (bev_v) begin
					pair_d.second = bev;
					pair_d.count  = 2'd2;
				end else begin
					pair_d.count = 2'd1;
				end
			end else if (bev_v) begin
				pair_d.first = bev;
				pair_d.count = 2'd1;
			end
		end

		if (pair_d.count == 2'd2) begin
			pair_d.second.last = 1'b1;
		end else if (pair_d.count == 2'd1) begin
			pair_d.first.last = 1'b1;
		end
	end

	assign load = advance;
	assign pair = pair_d;

	// Keep the stack top on the read port: address it from the depth the next word sees.
	assign depth_nx = advance ? depth_d : depth_q;
	assign raddr    = AW'(depth_nx - 1'b1);
	assign waddr    = AW'(depth_q);
	assign we       = advance && push;
	assign top      = byp_q ? byp_data_q : rdata;

	sst_ram #(
		.WIDTH (OFFSET_BITS),
		.DEPTH (MAX_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (pos_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			mode_q     <= M_BETWEEN;
			depth_q    <= '0;
			pos_q      <= '0;
			sstart_q   <= '0;
			byp_q      <= 1'b0;
		end else begin
			if (char_stream.ready) begin
				s1_valid_q <= char_stream.valid;
			end
			if (advance) begin
				mode_q   <= mode_d;
				depth_q  <= depth_d;
				pos_q    <= pos_d;
				sstart_q <= sstart_d;
			end
			byp_q <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.valid && char_stream.ready) begin
			kind_s1 <= char_stream.payload.kind;
			byte_s1 <= char_stream.payload.text_byte;
		end
		byp_data_q <= pos_q;
	end

	`SST_ASSERT(a_eot_clears, clk, arst_n, (advance && kind_s1) |=> (depth_q == '0 && pos_q == '0 && mode_q == M_BETWEEN), "end of text left state behind")
	`SST_ASSERT(a_error_sticks, clk, arst_n, (mode_q == M_ERROR && !(advance && kind_s1)) |=> (mode_q == M_ERROR), "error mode left before end of text")
	`SST_ASSERT(a_push_in_range, clk, arst_n, we |-> (depth_q < DW'(MAX_DEPTH) && depth_d == depth_q + 1'b1), "stack push at full depth")

endmodule

@@ rtl/sst_result_buf.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sst_result_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  sst_pkg::res_pair_t pair,
	output logic               take,
	sst_stream_if.source       token_stream
);

	logic [1:0]         cnt_q;
	sst_pkg::res_item_t slot0_q, slot1_q;
	logic               pop;

	assign token_stream.valid   = cnt_q != 2'd0;
	assign token_stream.payload = slot0_q;
	assign pop                  = token_stream.valid && token_stream.ready;
	// Free for the next pair once the final word leaves.
	assign take                 = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (take && load) begin
			cnt_q <= pair.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && load) begin
			slot0_q <= pair.first;
			slot1_q <= pair.second;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	`SST_ASSERT(a_cnt_range, clk, arst_n, cnt_q != 2'd3, "result count out of range")
	`SST_ASSERT(a_last_marks, clk, arst_n, (cnt_q != 2'd0) |-> (slot0_q.last == (cnt_q == 2'd1)), "last flag not on final word")
	`SST_ASSERT(a_pop_advances, clk, arst_n, (pop && cnt_q == 2'd2) |=> (cnt_q == 2'd1), "second word lost")

endmodule

@@ rtl/sexpr_stream_tokenizer.sv @@
`timescale 1ns / 1ps
// Path: an accepted input word is held in the lexer input register; the result words
// enter the output buffer once it takes the pair, and are offered from there.
// Throughput: one input word per cycle while the buffer takes each pair; two results
// (atom end, then a list, error or end event) hold the output buffer until both leave.
// Reset: asynchronous, clears mode, depth, position and buffers; the open-offset
// stack memory is not cleared, only entries below the current depth are used.

module sexpr_stream_tokenizer #(
	parameter int MAX_DEPTH   = sst_pkg::MAX_DEPTH_DEF,
	parameter int OFFSET_BITS = sst_pkg::OFFSET_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sst_stream_if.sink   char_stream,
	sst_stream_if.source token_stream
);

	logic               take;
	logic               load;
	sst_pkg::res_pair_t pair;

	sst_lexer #(
		.MAX_DEPTH   (MAX_DEPTH),
		.OFFSET_BITS (OFFSET_BITS)
	) u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_stream (char_stream),
		.take        (take),
		.load        (load),
		.pair        (pair)
	);

	sst_result_buf u_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.pair         (pair),
		.take         (take),
		.token_stream (token_stream)
	);

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import sst_pkg::*;

	localparam int STACK_DEPTH = MAX_DEPTH_DEF;

	typedef enum logic [2:0] {
		LX_BETWEEN,
		LX_COMMENT,
		LX_ATOM,
		LX_STRING,
		LX_ESCAPE,
		LX_ERROR
	} lex_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sst_stream_if #(.payload_t(char_item_t)) char_if ();
	sst_stream_if #(.payload_t(res_item_t)) token_if ();

	sexpr_stream_tokenizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_stream (char_if),
		.token_stream(token_if)
	);

	always #10 clk = ~clk;

	lex_mode_t   lx_mode;
	int          lx_depth;
	logic [31:0] lx_stack [STACK_DEPTH];
	logic [31:0] lx_str_start;
	logic [31:0] lx_pos;

	res_item_t   token_exp_q[$];
	logic [7:0]  doc_q[$];
	int          sent_words = 0;
	int          mismatch_count = 0;
	bit          src_calm = 1'b0;
	bit          sink_calm = 1'b0;

	function automatic void doc_add(input logic [7:0] c);
		doc_q.insert(doc_q.size(), c);
	endfunction

	function automatic void clear_lexer();
		lx_mode = LX_BETWEEN;
		lx_depth = 0;
		lx_str_start = '0;
		lx_pos = '0;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB ||
			c == CH_VT || c == CH_FF;
	endfunction

	function automatic void emit_token(input event_t ev, input logic [7:0] val,
			input logic [31:0] off);
		res_item_t r;
		r.event_res = ev;
		r.value = val;
		r.nest_depth = 7'(lx_depth);
		r.byte_offset = off;
		r.last = 1'b0;
		token_exp_q.insert(token_exp_q.size(), r);
	endfunction

	function automatic void lex_between(input logic [7:0] c, input logic [31:0] off);
		if (is_blank(c))
			return;
		if (c == CH_SEMI || c == CH_HASH) begin
			lx_mode = LX_COMMENT;
		end else if (c == CH_LPAREN) begin
			if (lx_depth >= STACK_DEPTH) begin
				// saturate and report
				lx_depth = STACK_DEPTH;
				emit_token(EV_OVERFLOW, 8'h00, off);
				lx_mode = LX_ERROR;
			end else begin
				lx_stack[lx_depth] = off;
				lx_depth++;
				emit_token(EV_OPEN, 8'h00, off);
			end
		end else if (c == CH_RPAREN) begin
			if (lx_depth == 0) begin
				emit_token(EV_UNEXP, 8'h00, off);
				lx_mode = LX_ERROR;
			end else begin
				lx_depth--;
				emit_token(EV_CLOSE, 8'h00, off);
			end
		end else if (c == CH_QUOTE) begin
			lx_str_start = off;
			lx_mode = LX_STRING;
		end else begin
			emit_token(EV_ABYTE, c, off);
			lx_mode = LX_ATOM;
		end
	endfunction

	function automatic void tokenize_word(input char_item_t w);
		int          n_prior;
		logic [31:0] off;
		logic [7:0]  c;
		res_item_t   r;
		n_prior = token_exp_q.size();
		off = lx_pos;
		c = w.text_byte;
		sent_words++;
		if (w.kind) begin
			case (lx_mode)
				LX_ERROR: ;
				LX_STRING, LX_ESCAPE: emit_token(EV_UNTERM, 8'h00, lx_str_start);
				default: begin
					if (lx_mode == LX_ATOM)
						emit_token(EV_AEND, 8'h00, off);
					if (lx_depth > 0)
						emit_token(EV_MISSING, 8'h00, lx_stack[lx_depth - 1]);
					else
						emit_token(EV_DONE, 8'h00, off);
				end
			endcase
			clear_lexer();
		end else begin
			lx_pos = lx_pos + 32'd1;
			case (lx_mode)
				LX_BETWEEN: lex_between(c, off);
				LX_COMMENT: begin
					if (c == CH_LF)
						lx_mode = LX_BETWEEN;
				end
				LX_ATOM: begin
					if (is_blank(c) || c == CH_LPAREN || c == CH_RPAREN) begin
						emit_token(EV_AEND, 8'h00, off);
						lx_mode = LX_BETWEEN;
						lex_between(c, off);
					end else begin
						emit_token(EV_ABYTE, c, off);
					end
				end
				LX_STRING: begin
					if (c == CH_QUOTE) begin
						emit_token(EV_SEND, 8'h00, off);
						lx_mode = LX_BETWEEN;
					end else if (c == CH_BSLASH) begin
						lx_mode = LX_ESCAPE;
					end else begin
						emit_token(EV_SBYTE, c, off);
					end
				end
				LX_ESCAPE: begin
					if (c == CH_N)
						emit_token(EV_SBYTE, CH_LF, off);
					else if (c == CH_R)
						emit_token(EV_SBYTE, CH_CR, off);
					else if (c == CH_T)
						emit_token(EV_SBYTE, CH_TAB, off);
					else
						emit_token(EV_SBYTE, c, off);
					lx_mode = LX_STRING;
				end
				default: lx_mode = LX_ERROR;
			endcase
		end
		// flag the final result of this word
		if (token_exp_q.size() > n_prior) begin
			r = token_exp_q[token_exp_q.size() - 1];
			r.last = 1'b1;
			token_exp_q[token_exp_q.size() - 1] = r;
		end
	endfunction

	task automatic send_word(input logic kind, input logic [7:0] c);
		char_item_t w;
		int         gap;
		w.kind = kind;
		w.text_byte = c;
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			char_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_if.valid <= 1'b1;
		char_if.payload <= w;
		@(posedge clk);
		while (!char_if.ready) @(posedge clk);
		tokenize_word(w);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(1'b0, s[i]);
	endtask

	task automatic finish_text();
		send_word(1'b1, 8'($urandom));
	endtask

	task automatic send_doc();
		foreach (doc_q[i])
			send_word(1'b0, doc_q[i]);
		finish_text();
	endtask

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_LF;
			2: return CH_CR;
			3: return CH_TAB;
			4: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] rand_atom_byte(input bit first);
		logic [7:0] c;
		do begin
			c = $urandom_range(0, 1) ? 8'($urandom_range(33, 126)) : 8'($urandom);
		end while (is_blank(c) || c == CH_LPAREN || c == CH_RPAREN ||
			(first && (c == CH_SEMI || c == CH_HASH || c == CH_QUOTE)));
		return c;
	endfunction

	function automatic void add_atom();
		int n;
		n = $urandom_range(1, 6);
		doc_add(rand_atom_byte(1'b1));
		for (int i = 1; i < n; i++)
			doc_add(rand_atom_byte(1'b0));
	endfunction

	function automatic void add_string(input bit closed);
		int         n;
		logic [7:0] c;
		n = $urandom_range(0, 8);
		doc_add(CH_QUOTE);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				doc_add(CH_BSLASH);
				case ($urandom_range(0, 6))
					0: c = CH_N;
					1: c = CH_R;
					2: c = CH_T;
					3: c = CH_BSLASH;
					4: c = CH_QUOTE;
					5: c = CH_LF;
					default: c = 8'($urandom);
				endcase
				doc_add(c);
			end else begin
				do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
				doc_add(c);
				if ($urandom_range(0, 5) == 0)
					doc_add(CH_LF);
			end
		end
		if (closed)
			doc_add(CH_QUOTE);
	endfunction

	function automatic void add_comment();
		logic [7:0] c;
		doc_add($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
		repeat ($urandom_range(0, 6)) begin
			do c = 8'($urandom); while (c == CH_LF);
			doc_add(c);
		end
		doc_add(CH_LF);
	endfunction

	// Well-formed text with random content; some texts are cut short or left open.
	function automatic void build_doc(input bit deep);
		int depth;
		int cap;
		int n_tok;
		int pick;
		doc_q.delete();
		depth = 0;
		cap = deep ? STACK_DEPTH + 2 : 6;
		n_tok = deep ? 80 : $urandom_range(2, 30);
		for (int i = 0; i < n_tok; i++) begin
			pick = $urandom_range(0, 99);
			if (depth < cap && (pick < 20 || (deep && pick < 75))) begin
				doc_add(CH_LPAREN);
				depth++;
			end else if (pick < 38 && depth > 0) begin
				doc_add(CH_RPAREN);
				depth--;
			end else if (pick < 62) begin
				add_atom();
			end else if (pick < 82) begin
				add_string(1'b1);
			end else if (pick < 92) begin
				add_comment();
			end else begin
				repeat ($urandom_range(1, 3)) doc_add(rand_blank());
			end
			doc_add(rand_blank());
		end
		if ($urandom_range(0, 4) != 0) begin
			while (depth > 0) begin
				doc_add(CH_RPAREN);
				depth--;
			end
		end
		case ($urandom_range(0, 9))
			0: add_string(1'b0);
			1: add_atom();
			2: if (doc_q.size() > 1) doc_q = doc_q[0:$urandom_range(0, doc_q.size() - 1)];
			default: ;
		endcase
	endfunction

	function automatic void build_noise();
		logic [7:0] c;
		doc_q.delete();
		repeat ($urandom_range(1, 30)) begin
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					0: c = CH_LPAREN;
					1: c = CH_RPAREN;
					2: c = CH_SEMI;
					3: c = CH_HASH;
					4: c = CH_QUOTE;
					5: c = CH_BSLASH;
					6: c = CH_LF;
					7: c = CH_N;
					8: c = rand_blank();
					default: c = CH_T;
				endcase
			end else begin
				c = 8'($urandom);
			end
			doc_add(c);
		end
	endfunction

	task automatic test_lists_atoms();
		finish_text();
		send_text("(ab");
		send_word(1'b0, 8'hFF);
		send_word(1'b0, 8'h00);
		send_text(" (c))\tx");
		finish_text();
	endtask

	task automatic test_strings();
		send_text("\"\" \"a\\n\\r\\t\\\\\\\"\\q\n\"");
		finish_text();
	endtask

	task automatic test_comments();
		send_text("; (x\n# )\n(a;#\"b");
		send_word(1'b0, CH_VT);
		send_text(")");
		send_word(1'b0, CH_FF);
		finish_text();
	endtask

	task automatic test_errors();
		send_text(")a(");
		finish_text();
		send_text("((a");
		finish_text();
		send_text("(\"a\\");
		finish_text();
	endtask

	task automatic test_overflow();
		repeat (STACK_DEPTH + 1) send_word(1'b0, CH_LPAREN);
		send_text(")x");
		finish_text();
		repeat (STACK_DEPTH) send_word(1'b0, CH_LPAREN);
		finish_text();
	endtask

	task automatic test_random_docs(input int n_words);
		int target;
		target = sent_words + n_words;
		while (sent_words < target) begin
			build_doc($urandom_range(0, 24) == 0);
			send_doc();
		end
	endtask

	task automatic test_random_noise(input int n_words);
		int target;
		target = sent_words + n_words;
		while (sent_words < target) begin
			build_noise();
			send_doc();
		end
	endtask

	// Result side: random stalls, then compare each word with the oldest expectation.
	initial begin
		res_item_t got;
		res_item_t want;
		int        stall;
		token_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
			stall = sink_calm ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				token_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			token_if.ready <= 1'b1;
			@(posedge clk);
			while (!token_if.valid) @(posedge clk);
			got = token_if.payload;
			if (token_exp_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word: event %0d value %h depth %0d offset %h last %b",
					$time, got.event_res, got.value, got.nest_depth, got.byte_offset,
					got.last);
			end else begin
				want = token_exp_q.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: expected event %0d value %h depth %0d offset %h last %b",
						$time, want.event_res, want.value, want.nest_depth,
						want.byte_offset, want.last);
					$display("%0t: actual   event %0d value %h depth %0d offset %h last %b",
						$time, got.event_res, got.value, got.nest_depth,
						got.byte_offset, got.last);
				end
			end
		end
	end

	initial begin
		clear_lexer();
		char_if.valid <= 1'b0;
		char_if.payload <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_lists_atoms();
		test_strings();
		test_comments();
		test_errors();
		test_overflow();
		test_random_docs(1250);
		test_random_noise(400);

		char_if.valid <= 1'b0;
		for (int w = 0; w < 10000 && token_exp_q.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (token_exp_q.size() != 0)
			$display("%0t: %0d expected words never arrived", $time, token_exp_q.size());
		if (mismatch_count == 0 && token_exp_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
